[sv/sphere_triangle_index_generator_defines.svh]
// Assertion helpers shared by the sphere triangle index generator modules.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef SPHERE_TRIANGLE_INDEX_GENERATOR_DEFINES_SVH
`define SPHERE_TRIANGLE_INDEX_GENERATOR_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define STI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define STI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sti_pkg.sv]
`timescale 1ns / 1ps

package sti_pkg;

  // Fixed field widths.
  localparam int RING_W    = 16;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // Default geometry limit.
  localparam int MAX_DIV_DEFAULT = 256;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STACKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLICES = 2'd1;

  // Register reset values.
  localparam logic [CFG_W-1:0] STACKS_RESET = 9'd16;
  localparam logic [CFG_W-1:0] SLICES_RESET = 9'd16;

  // Lower limits of the geometry registers.
  localparam logic [CFG_W-1:0] STACKS_MIN = 9'd2;
  localparam logic [CFG_W-1:0] SLICES_MIN = 9'd3;

  // Ring base of the first ring.
  localparam logic [RING_W-1:0] FIRST_RING_BASE = 16'd1;

  // Saturated geometry handed to the walker.
  typedef struct packed {
    logic [CFG_W-1:0] stacks;
    logic [CFG_W-1:0] slices;
  } geom_t;

  // One triangle.
  typedef struct packed {
    logic [RING_W-1:0] a;
    logic [RING_W-1:0] b;
    logic [RING_W-1:0] c;
    logic              fin;
  } tri_t;

endpackage

[sv/sphere_triangle_index_generator.sv]
// An accepted input transaction is registered in the input stage, then in the result register.
// Throughput: one triangle per cycle while out_stall is low; the walker updates its counters in a single pass.
// A full sphere takes 2*slice_count*(stack_count-1) transactions.
// Reset (rst_n low, synchronous) empties both stages and returns both registers to 16.
// Reset also puts the walker on the first triangle of the top cap.
`timescale 1ns / 1ps
`include "sphere_triangle_index_generator_defines.svh"

module sphere_triangle_index_generator #(
  parameter int MAX_DIVISIONS = sti_pkg::MAX_DIV_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sti_pkg::RING_W-1:0]    out_vertex_a,
  output logic [sti_pkg::RING_W-1:0]    out_vertex_b,
  output logic [sti_pkg::RING_W-1:0]    out_vertex_c,
  output logic                          out_final_triangle,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sti_pkg::CFG_W-1:0]     cfg_data
);

  sti_pkg::geom_t geom;
  sti_pkg::tri_t  tri_c;
  logic           seq_clear;

  logic           stg_valid_r;
  logic           stg_restart_r;
  logic           out_valid_r;
  sti_pkg::tri_t  out_tri_r;
  logic           advance;
  logic           in_take;

  sti_config #(
    .MAX_DIVISIONS(MAX_DIVISIONS)
  ) u_config (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .geom     (geom),
    .seq_clear(seq_clear)
  );

  sti_walker #(
    .MAX_DIVISIONS(MAX_DIVISIONS)
  ) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .seq_clear(seq_clear),
    .step     (advance),
    .restart  (stg_restart_r),
    .tri_out  (tri_c)
  );

  // The staged item moves on whenever the result register is free or draining.
  assign advance  = stg_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stg_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_take) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_restart_r <= in_restart;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tri_r <= tri_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_vertex_a       = out_tri_r.a;
  assign out_vertex_b       = out_tri_r.b;
  assign out_vertex_c       = out_tri_r.c;
  assign out_final_triangle = out_tri_r.fin;

  // A staged item never waits while the result register is empty.
  `STI_ASSERT_SAME(a_no_bubble, stg_valid_r && !out_valid_r, advance, "staged item held")
  // A processed transaction always shows up as a result in the next cycle.
  `STI_ASSERT_NEXT(a_result_follows, advance, out_valid_r, "lost result")
  // A stalled result stays valid and unchanged.
  `STI_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_tri_r), "result moved")

endmodule

[sv/sti_config.sv]
`timescale 1ns / 1ps

module sti_config #(
  parameter int MAX_DIVISIONS = sti_pkg::MAX_DIV_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sti_pkg::CFG_W-1:0]     cfg_data,
  output sti_pkg::geom_t                geom,
  output logic                          seq_clear
);

  localparam logic [sti_pkg::CFG_W-1:0] MAX_VAL = sti_pkg::CFG_W'(MAX_DIVISIONS);

  logic [sti_pkg::CFG_W-1:0] stacks_r;
  logic [sti_pkg::CFG_W-1:0] slices_r;
  logic                      wr_stacks;
  logic                      wr_slices;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr_stacks = cfg_valid && (cfg_index == sti_pkg::CFG_IDX_STACKS);
  assign wr_slices = cfg_valid && (cfg_index == sti_pkg::CFG_IDX_SLICES);

  // Any write to a defined register restarts the triangle sequence.
  assign seq_clear = wr_stacks || wr_slices;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stacks_r <= sti_pkg::STACKS_RESET;
      slices_r <= sti_pkg::SLICES_RESET;
    end else begin
      if (wr_stacks) begin
        stacks_r <= cfg_data;
      end
      if (wr_slices) begin
        slices_r <= cfg_data;
      end
    end
  end

  // Saturate both counts into their legal ranges.
  always_comb begin
    if (stacks_r < sti_pkg::STACKS_MIN) begin
      geom.stacks = sti_pkg::STACKS_MIN;
    end else if (stacks_r > MAX_VAL) begin
      geom.stacks = MAX_VAL;
    end else begin
      geom.stacks = stacks_r;
    end
    if (slices_r < sti_pkg::SLICES_MIN) begin
      geom.slices = sti_pkg::SLICES_MIN;
    end else if (slices_r > MAX_VAL) begin
      geom.slices = MAX_VAL;
    end else begin
      geom.slices = slices_r;
    end
  end

endmodule

[sv/sti_walker.sv]
`timescale 1ns / 1ps
`include "sphere_triangle_index_generator_defines.svh"

module sti_walker #(
  parameter int MAX_DIVISIONS = sti_pkg::MAX_DIV_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sti_pkg::geom_t geom,
  input  logic           seq_clear,
  input  logic           step,
  input  logic           restart,
  output sti_pkg::tri_t  tri_out
);

  localparam int CNT_W = $clog2(MAX_DIVISIONS);
  localparam int DIV_W = CNT_W + 1;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_BAND,
    PH_BOTTOM
  } phase_t;

  phase_t                     phase_r, phase_nxt, cur_phase;
  logic [CNT_W-1:0]           band_r, band_nxt, cur_band;
  logic [CNT_W-1:0]           pos_r, pos_nxt, cur_pos;
  logic                       half_r, half_nxt, cur_half;
  logic [sti_pkg::RING_W-1:0] base_r, base_nxt, cur_base;

  logic                       seq_restart;
  logic [DIV_W-1:0]           stacks;
  logic [DIV_W-1:0]           slices;
  logic [sti_pkg::RING_W-1:0] slices_w;
  logic                       last;
  logic [sti_pkg::RING_W-1:0] tl, tr;
  logic                       at_home;

  assign stacks   = geom.stacks[DIV_W-1:0];
  assign slices   = geom.slices[DIV_W-1:0];
  assign slices_w = sti_pkg::RING_W'(slices);

  // A restart or an unknown phase begins from the first triangle.
  assign seq_restart = restart || (phase_r != PH_TOP && phase_r != PH_BAND &&
                                   phase_r != PH_BOTTOM);

  always_comb begin
    if (seq_restart) begin
      cur_phase = PH_TOP;
      cur_band  = '0;
      cur_pos   = '0;
      cur_half  = 1'b0;
      cur_base  = sti_pkg::FIRST_RING_BASE;
    end else begin
      cur_phase = phase_r;
      cur_band  = band_r;
      cur_pos   = pos_r;
      cur_half  = half_r;
      cur_base  = base_r;
    end
  end

  // Corners of the current quad; the right corner wraps at the ring end.
  assign last = (DIV_W'(cur_pos) + DIV_W'(1)) >= slices;
  assign tl   = cur_base + sti_pkg::RING_W'(cur_pos);
  assign tr   = last ? cur_base : tl + sti_pkg::RING_W'(1);

  // Triangle selection and sequence advance.
  always_comb begin
    phase_nxt   = cur_phase;
    band_nxt    = cur_band;
    pos_nxt     = cur_pos + CNT_W'(1);
    half_nxt    = cur_half;
    base_nxt    = cur_base;
    tri_out.fin = 1'b0;
    case (cur_phase)
      PH_TOP: begin
        tri_out.a = '0;
        tri_out.b = tr;
        tri_out.c = tl;
        if (last) begin
          pos_nxt  = '0;
          base_nxt = sti_pkg::FIRST_RING_BASE;
          if (stacks > DIV_W'(2)) begin
            phase_nxt = PH_BAND;
            band_nxt  = CNT_W'(1);
          end else begin
            phase_nxt = PH_BOTTOM;
          end
        end
      end
      PH_BAND: begin
        if (!cur_half) begin
          tri_out.a = tl;
          tri_out.b = tr;
          tri_out.c = tl + slices_w;
          half_nxt  = 1'b1;
          pos_nxt   = cur_pos;
        end else begin
          tri_out.a = tr;
          tri_out.b = tr + slices_w;
          tri_out.c = tl + slices_w;
          half_nxt  = 1'b0;
          if (last) begin
            pos_nxt  = '0;
            base_nxt = cur_base + slices_w;
            if ((DIV_W'(cur_band) + DIV_W'(2)) >= stacks) begin
              phase_nxt = PH_BOTTOM;
            end else begin
              band_nxt = cur_band + CNT_W'(1);
            end
          end
        end
      end
      PH_BOTTOM: begin
        tri_out.a = tl;
        tri_out.b = tr;
        tri_out.c = cur_base + slices_w;
        if (last) begin
          tri_out.fin = 1'b1;
          phase_nxt   = PH_TOP;
          band_nxt    = '0;
          pos_nxt     = '0;
          half_nxt    = 1'b0;
          base_nxt    = sti_pkg::FIRST_RING_BASE;
        end
      end
      default: begin
        tri_out.a = '0;
        tri_out.b = '0;
        tri_out.c = '0;
        phase_nxt = PH_TOP;
        band_nxt  = '0;
        pos_nxt   = '0;
        half_nxt  = 1'b0;
        base_nxt  = sti_pkg::FIRST_RING_BASE;
      end
    endcase
  end

  // Sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n || seq_clear) begin
      phase_r <= PH_TOP;
      band_r  <= '0;
      pos_r   <= '0;
      half_r  <= 1'b0;
      base_r  <= sti_pkg::FIRST_RING_BASE;
    end else if (step) begin
      phase_r <= phase_nxt;
      band_r  <= band_nxt;
      pos_r   <= pos_nxt;
      half_r  <= half_nxt;
      base_r  <= base_nxt;
    end
  end

  // The walker sits on the first triangle of the top cap.
  assign at_home = phase_r == PH_TOP && pos_r == '0 && base_r == sti_pkg::FIRST_RING_BASE;

  // A register write leaves the walker at the first triangle of the top cap.
  `STI_ASSERT_NEXT(a_clear_home, seq_clear, at_home, "walker not home after clear")
  // Every top cap triangle starts at the top apex.
  `STI_ASSERT_SAME(a_top_apex, step && cur_phase == PH_TOP, tri_out.a == '0, "apex missing")
  // The final flag only appears in the bottom cap at the end of a ring.
  `STI_ASSERT_SAME(a_fin_place, tri_out.fin, cur_phase == PH_BOTTOM && last, "stray final flag")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int REPORT_LIMIT   = 10;

  // Register indexes that decode to no register; writes there must change nothing.
  localparam logic [sti_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [sti_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    WALK_TOP_CAP    = 2'd0,
    WALK_BANDS      = 2'd1,
    WALK_BOTTOM_CAP = 2'd2
  } walk_phase_t;

  // Tracks the sphere walk and holds the triangles still owed by the block.
  class sphere_index_tracker;
    logic [sti_pkg::CFG_W-1:0]  stacks_reg;
    logic [sti_pkg::CFG_W-1:0]  slices_reg;
    walk_phase_t                phase;
    logic [7:0]                 band;
    logic [7:0]                 slice_pos;
    logic                       lower_half;
    logic [sti_pkg::RING_W-1:0] ring_base;
    sti_pkg::tri_t              expected_q[$];
    int                         mismatches;

    function new();
      stacks_reg = sti_pkg::STACKS_RESET;
      slices_reg = sti_pkg::SLICES_RESET;
      mismatches = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      phase      = WALK_TOP_CAP;
      band       = 8'd0;
      slice_pos  = 8'd0;
      lower_half = 1'b0;
      ring_base  = sti_pkg::FIRST_RING_BASE;
    endfunction

    // A write to a real register also puts the walk back on the first triangle.
    function void write_reg(logic [sti_pkg::CFG_IDX_W-1:0] idx,
                            logic [sti_pkg::CFG_W-1:0] val);
      if (idx == sti_pkg::CFG_IDX_STACKS) begin
        stacks_reg = val;
        restart_walk();
      end else if (idx == sti_pkg::CFG_IDX_SLICES) begin
        slices_reg = val;
        restart_walk();
      end
    endfunction

    function logic [sti_pkg::CFG_W-1:0] clip(logic [sti_pkg::CFG_W-1:0] v,
                                             logic [sti_pkg::CFG_W-1:0] lo);
      if (v < lo) return lo;
      if (v > sti_pkg::MAX_DIV_DEFAULT) return sti_pkg::CFG_W'(sti_pkg::MAX_DIV_DEFAULT);
      return v;
    endfunction

    // Works out the triangle for one accepted input transaction.
    function void note_input(logic restart);
      logic [sti_pkg::CFG_W-1:0]  t;
      logic [sti_pkg::CFG_W-1:0]  s;
      logic [sti_pkg::RING_W-1:0] s16;
      logic [sti_pkg::RING_W-1:0] tl;
      logic [sti_pkg::RING_W-1:0] tr;
      logic                       last;
      sti_pkg::tri_t              want;
      t   = clip(stacks_reg, sti_pkg::STACKS_MIN);
      s   = clip(slices_reg, sti_pkg::SLICES_MIN);
      s16 = sti_pkg::RING_W'(s);
      if (restart || phase > WALK_BOTTOM_CAP) restart_walk();
      last = ({1'b0, slice_pos} + 9'd1) >= s;
      tl   = ring_base + sti_pkg::RING_W'(slice_pos);
      tr   = last ? ring_base : tl + 16'd1;
      want.fin = 1'b0;
      case (phase)
        WALK_TOP_CAP: begin
          want.a = '0;
          want.b = tr;
          want.c = tl;
          if (last) begin
            slice_pos = 8'd0;
            ring_base = sti_pkg::FIRST_RING_BASE;
            if (t > sti_pkg::STACKS_MIN) begin
              phase = WALK_BANDS;
              band  = 8'd1;
            end else begin
              phase = WALK_BOTTOM_CAP;
            end
          end else begin
            slice_pos++;
          end
        end
        WALK_BANDS: begin
          if (!lower_half) begin
            want.a     = tl;
            want.b     = tr;
            want.c     = tl + s16;
            lower_half = 1'b1;
          end else begin
            want.a     = tr;
            want.b     = tr + s16;
            want.c     = tl + s16;
            lower_half = 1'b0;
            if (last) begin
              slice_pos = 8'd0;
              ring_base = ring_base + s16;
              if (({1'b0, band} + 9'd2) >= t) phase = WALK_BOTTOM_CAP;
              else band = band + 8'd1;
            end else begin
              slice_pos++;
            end
          end
        end
        default: begin
          want.a = tl;
          want.b = tr;
          want.c = ring_base + s16;
          if (last) begin
            want.fin = 1'b1;
            restart_walk();
          end else begin
            slice_pos++;
          end
        end
      endcase
      expected_q.insert(expected_q.size(), want);
    endfunction

    // Compares one accepted result transaction with the oldest expected triangle.
    function void check_result(sti_pkg::tri_t got);
      sti_pkg::tri_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected triangle: got %0d %0d %0d final %0d",
                   got.a, got.b, got.c, got.fin);
        return;
      end
      want = expected_q.pop_front();
      if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
          got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("triangle mismatch: expected %0d %0d %0d final %0d, %s %0d %0d %0d final %0d",
                   want.a, want.b, want.c, want.fin, "got",
                   got.a, got.b, got.c, got.fin);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_restart = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [sti_pkg::RING_W-1:0]    out_vertex_a;
  logic [sti_pkg::RING_W-1:0]    out_vertex_b;
  logic [sti_pkg::RING_W-1:0]    out_vertex_c;
  logic                          out_final_triangle;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sti_pkg::CFG_IDX_W-1:0] cfg_index = sti_pkg::CFG_IDX_STACKS;
  logic [sti_pkg::CFG_W-1:0]     cfg_data = '0;

  sphere_index_tracker tracker = new();
  int in_idle_pct  = 23;
  int out_idle_pct = 78;
  int items_sent   = 0;
  int quiet_cycles = 0;

  sphere_triangle_index_generator #(
    .MAX_DIVISIONS(sti_pkg::MAX_DIV_DEFAULT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vertex_a       (out_vertex_a),
    .out_vertex_b       (out_vertex_b),
    .out_vertex_c       (out_vertex_c),
    .out_final_triangle (out_final_triangle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check accepted triangles, stall at random, and watch for a hang.
  always @(posedge clk) begin : result_monitor
    sti_pkg::tri_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.a   = out_vertex_a;
      seen.b   = out_vertex_b;
      seen.c   = out_vertex_c;
      seen.fin = out_final_triangle;
      tracker.check_result(seen);
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    out_stall <= ($urandom_range(99) < out_idle_pct);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The idle mix moves on with the number of input transactions sent.
  function void pick_idle_mix();
    if (items_sent < 560) begin
      in_idle_pct  = 23;
      out_idle_pct = 78;
    end else if (items_sent < 1120) begin
      in_idle_pct  = 78;
      out_idle_pct = 23;
    end else begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end
  endfunction

  // Sends one input transaction; valid stays high afterward for back-to-back items.
  task automatic push_item(input logic restart);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_input(restart);
    items_sent++;
    pick_idle_mix();
  endtask

  // Drops valid and waits until every owed triangle has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sti_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic set_geometry(input logic [sti_pkg::CFG_W-1:0] stacks,
                              input logic [sti_pkg::CFG_W-1:0] slices);
    wait_idle();
    write_reg(sti_pkg::CFG_IDX_STACKS, stacks);
    write_reg(sti_pkg::CFG_IDX_SLICES, slices);
    cfg_valid <= 1'b0;
  endtask

  // Random restarts come at restart_pm per thousand; one pause drains the block.
  task automatic run_items(input int count, input int restart_pm, input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_q.size() != 0) @(posedge clk);
      end
      push_item($urandom_range(999) < restart_pm);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Default geometry with restarts in the middle of the top cap.
    push_item(1'b1);
    repeat (3) push_item(1'b0);
    push_item(1'b1);
    push_item(1'b0);

    // Two stacks: top cap straight into the bottom cap, then the wrap to the start.
    set_geometry(9'd2, 9'd3);
    run_items(7, 0, -1);

    // Registers below and above their range are saturated.
    set_geometry(9'd0, 9'd1);
    run_items(4, 0, -1);
    set_geometry(9'd511, 9'd511);
    run_items(3, 0, -1);

    // Writes to undecoded indexes must leave the walk where it is.
    wait_idle();
    write_reg(CFG_IDX_SPARE_A, 9'($urandom));
    write_reg(CFG_IDX_SPARE_B, 9'($urandom));
    cfg_valid <= 1'b0;
    run_items(2, 0, -1);

    // Random part: walks at small and extreme sizes, some of them through a full sphere.
    set_geometry(9'd5, 9'd4);
    run_items(250, 33, 125);
    set_geometry(9'd2, 9'd256);
    run_items(520, 0, -1);
    set_geometry(9'd256, 9'd3);
    run_items(300, 0, -1);
    repeat (4) begin
      set_geometry(9'($urandom_range(12, 2)), 9'($urandom_range(12, 3)));
      run_items(120, 50, -1);
    end
    set_geometry(9'($urandom_range(511, 257)), 9'($urandom_range(2, 0)));
    run_items(80, 20, -1);

    wait_idle();
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sti_pkg.sv
sv/sti_config.sv
sv/sti_walker.sv
sv/sphere_triangle_index_generator.sv
tb/sv/tb.sv
